[hw/rtl/frac_pkg.sv]
// ----------------------------------------------------------------------------
// frac_pkg
// Shared types for the fraction arithmetic unit: operation codes, payloads,
// controller command and datapath status structures.
// ----------------------------------------------------------------------------
package frac_pkg;

  localparam int unsigned FieldBits = 32;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_SUB    = 3'd1,
    FUNC_MUL    = 3'd2,
    FUNC_DIV    = 3'd3,
    FUNC_REDUCE = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0]           func;
    logic [FieldBits-1:0] num_a;
    logic [FieldBits-1:0] den_a;
    logic [FieldBits-1:0] num_b;
    logic [FieldBits-1:0] den_b;
  } frac_in_t;

  typedef struct packed {
    logic [FieldBits-1:0] num_out;
    logic [FieldBits-1:0] den_out;
    logic                 reduced;
  } frac_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD1,
    ST_PROD2,
    ST_COMBINE,
    ST_CLASSIFY,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic prod1;
    logic prod2;
    logic combine;
    logic classify;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_sel_d;
    logic finish;
  } frac_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } frac_sts_t;

endpackage

[hw/rtl/fraction_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit_core
// Signed fraction add/subtract/multiply/divide/reduce with gcd reduction.
// ----------------------------------------------------------------------------
// channel | valid       | ready       | payload
// in      | in_valid_i  | in_ready_o  | in_data_i  (frac_in_t)
// out     | out_valid_o | out_ready_i | out_data_o (frac_out_t)
//
// One item at a time: products, combine and classification, a binary gcd
// loop and a handover to the divider, two divisions on one shared divider,
// then a finish step; special cases skip gcd and division. Reset clears the
// sequencer only.
// The result holds until the transfer; input is not ready until then.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frac_pkg::frac_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frac_pkg::frac_out_t out_data_o
);
  import frac_pkg::*;

  frac_cmd_t cmd;
  frac_sts_t sts;

  frac_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  frac_dp #(.WordBits(WORD_BITS)) u_dp (
    .clk_i, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o) else $error("no return to idle");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted twice");

endmodule

[hw/rtl/frac_ctrl.sv]
// ----------------------------------------------------------------------------
// frac_ctrl
// Sequencer: products, combine, classify, gcd loop, two divisions, output.
// ----------------------------------------------------------------------------
module frac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frac_pkg::frac_cmd_t cmd_o,
  input  frac_pkg::frac_sts_t sts_i
);
  import frac_pkg::*;

  state_e state_q, state_d;
  logic   div_first_q, div_first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_first_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_first_q <= div_first_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_first_d = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PROD1;
        end
      end
      ST_PROD1: begin
        cmd_o.prod1 = 1'b1;
        state_d     = ST_PROD2;
      end
      ST_PROD2: begin
        cmd_o.prod2 = 1'b1;
        state_d     = ST_COMBINE;
      end
      ST_COMBINE: begin
        cmd_o.combine = 1'b1;
        state_d       = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        state_d        = sts_i.special ? ST_FINISH : ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_start = 1'b1;
          div_first_d     = 1'b1;
          state_d         = ST_DIV_N;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV_N: begin
        cmd_o.div_step = !div_first_q;
        if (sts_i.div_done && !div_first_q) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_d = 1'b1;
          div_first_d     = 1'b1;
          state_d         = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        cmd_o.div_sel_d = 1'b1;
        cmd_o.div_step  = !div_first_q;
        if (sts_i.div_done && !div_first_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/frac_dp.sv]
// ----------------------------------------------------------------------------
// frac_dp
// Datapath: cross products, binary gcd and restoring division by the gcd.
// ----------------------------------------------------------------------------
module frac_dp #(
  parameter int unsigned WordBits = 32
) (
  input  logic                 clk_i,
  input  frac_pkg::frac_in_t   in_i,
  input  frac_pkg::frac_cmd_t  cmd_i,
  output frac_pkg::frac_sts_t  sts_o,
  output frac_pkg::frac_out_t  out_o
);
  import frac_pkg::*;

  localparam int unsigned CntBits = $clog2(WordBits + 1);
  localparam int unsigned ShBits  = $clog2(WordBits + 1);

  logic [2:0]          func_q;
  logic [WordBits-1:0] na_q, da_q, nb_q, db_q;
  logic [WordBits-1:0] p1_q, p2_q, p3_q;
  logic [WordBits-1:0] n_q, d_q;
  logic [WordBits-1:0] ga_q, gb_q;
  logic [ShBits-1:0]   gsh_q;
  logic [WordBits-1:0] g_q;
  logic [WordBits-1:0] dividend_q, quot_q, qn_q;
  logic [WordBits-1:0] rem_q;
  logic [CntBits-1:0]  cnt_q;
  logic                special_q, flag_q;
  logic [WordBits-1:0] mult_a, mult_b, mult_p;

  function automatic logic [WordBits-1:0] sext(input logic [FieldBits-1:0] v);
    logic [WordBits+FieldBits-1:0] t;
    t = {{WordBits{v[FieldBits-1]}}, v};
    return t[WordBits-1:0];
  endfunction

  function automatic logic [FieldBits-1:0] tofield(input logic [WordBits-1:0] v);
    logic [WordBits+FieldBits-1:0] t;
    t = {{FieldBits{v[WordBits-1]}}, v};
    return t[FieldBits-1:0];
  endfunction

  function automatic logic [WordBits-1:0] mag(input logic [WordBits-1:0] v);
    return v[WordBits-1] ? (~v + 1'b1) : v;
  endfunction

  // shared multiplier for the first two products, wrapped to word width;
  // num_a * den_b has a multiplier of its own
  always_comb begin
    mult_a = na_q;
    mult_b = db_q;
    if (cmd_i.prod1) begin
      mult_a = (func_q == FUNC_MUL) ? na_q : ((func_q == FUNC_DIV) ? da_q : nb_q);
      mult_b = (func_q == FUNC_MUL) ? nb_q : ((func_q == FUNC_DIV) ? nb_q : da_q);
    end else if (cmd_i.prod2) begin
      mult_a = da_q;
      mult_b = db_q;
    end
    mult_p = mult_a * mult_b;
  end

  logic [WordBits-1:0] diff_g;
  logic                gb_zero;
  assign gb_zero = (gb_q == '0);
  assign diff_g  = (ga_q > gb_q) ? (ga_q - gb_q) : (gb_q - ga_q);

  logic [WordBits:0]   rem_sh;
  logic [WordBits:0]   rem_sub;
  assign rem_sh  = {rem_q, dividend_q[WordBits-1]};
  assign rem_sub = rem_sh - {1'b0, g_q};

  logic [WordBits-1:0] n_mag_res, d_mag_res;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_i.func;
      na_q   <= sext(in_i.num_a);
      da_q   <= sext(in_i.den_a);
      nb_q   <= sext(in_i.num_b);
      db_q   <= sext(in_i.den_b);
    end
    if (cmd_i.prod1) p1_q <= mult_p;
    if (cmd_i.prod2) p2_q <= mult_p;
    if (cmd_i.prod1) p3_q <= na_q * db_q;
    if (cmd_i.combine) begin
      case (func_q)
        FUNC_ADD: begin n_q <= p3_q + p1_q; d_q <= p2_q; end
        FUNC_SUB: begin n_q <= p3_q - p1_q; d_q <= p2_q; end
        FUNC_MUL: begin n_q <= p1_q;        d_q <= p2_q; end
        FUNC_DIV: begin n_q <= p3_q;        d_q <= p1_q; end
        default:  begin n_q <= na_q;        d_q <= da_q; end
      endcase
    end
    if (cmd_i.classify) begin
      special_q <= (n_q == d_q) || (n_q == '0) || (d_q == '0);
      ga_q      <= mag(n_q);
      gb_q      <= mag(d_q);
      gsh_q     <= '0;
      flag_q    <= (n_q == d_q) || (n_q == '0);
    end
    // binary gcd: strip shared twos, drop lone twos from either, then subtract
    if (cmd_i.gcd_step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q  <= ga_q >> 1;
        gb_q  <= gb_q >> 1;
        gsh_q <= gsh_q + 1'b1;
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else begin
        ga_q <= (ga_q < gb_q) ? ga_q : gb_q;
        gb_q <= diff_g;
      end
    end
    if (cmd_i.div_start) begin
      if (!cmd_i.div_sel_d) g_q <= ga_q << gsh_q;
      dividend_q <= cmd_i.div_sel_d ? mag(d_q) : mag(n_q);
      rem_q      <= '0;
      cnt_q      <= '0;
      if (cmd_i.div_sel_d) qn_q <= quot_q;
    end
    if (cmd_i.div_step && (cnt_q != CntBits'(WordBits))) begin
      dividend_q <= dividend_q << 1;
      if (!rem_sub[WordBits]) begin
        rem_q  <= rem_sub[WordBits-1:0];
        quot_q <= {quot_q[WordBits-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[WordBits-1:0];
        quot_q <= {quot_q[WordBits-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      if (special_q) begin
        if (n_q == d_q) begin
          n_q <= WordBits'(1); d_q <= WordBits'(1);
        end else if (n_q == '0) begin
          d_q <= WordBits'(1);
        end else if (n_q[WordBits-1] && d_q[WordBits-1]) begin
          n_q <= ~n_q + 1'b1; d_q <= ~d_q + 1'b1;
        end
      end else begin
        if (g_q != WordBits'(1)) flag_q <= 1'b1;
        n_q <= n_mag_res;
        d_q <= d_mag_res;
      end
    end
  end

  // sign reapplication then both-negative fix
  logic [WordBits-1:0] nr, dr;
  always_comb begin
    nr = (g_q != WordBits'(1)) ? (n_q[WordBits-1] ? ~qn_q + 1'b1 : qn_q) : n_q;
    dr = (g_q != WordBits'(1)) ? (d_q[WordBits-1] ? ~quot_q + 1'b1 : quot_q) : d_q;
    n_mag_res = (nr[WordBits-1] && dr[WordBits-1]) ? ~nr + 1'b1 : nr;
    d_mag_res = (nr[WordBits-1] && dr[WordBits-1]) ? ~dr + 1'b1 : dr;
  end

  assign sts_o.special  = (n_q == d_q) || (n_q == '0) || (d_q == '0);
  assign sts_o.gcd_done = gb_zero;
  assign sts_o.div_done = (cnt_q == CntBits'(WordBits));

  assign out_o.num_out = tofield(n_q);
  assign out_o.den_out = tofield(d_q);
  assign out_o.reduced = flag_q;

endmodule
